### rtl/core/cwid_pkg.sv
// ----------------------------------------------------------------------------
// cwid_pkg
// Types and constants shared by the checked-width integer divider.
// ----------------------------------------------------------------------------
package cwid_pkg;

   localparam int DATA_W        = 64;
   localparam int OPW_W         = 7;
   localparam int MAX_WIDTH_DEF = 64;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_TYPE = 2'd1,
      STATUS_DIV0 = 2'd2,
      STATUS_OVF  = 2'd3
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
      logic [OPW_W-1:0]  operand_width;
      logic              signed_mode;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] quotient;
      status_type        status;
   } rsp_type;

   // control that travels alongside the divide data
   typedef struct packed {
      logic             valid;
      status_type       status;
      logic             neg_q;
      logic [OPW_W-1:0] width;
   } ctl_type;

endpackage

### rtl/core/cwid_check.sv
// ----------------------------------------------------------------------------
// cwid_check
// Front stage: width and range checks, status priority, operand magnitudes.
// ----------------------------------------------------------------------------
module cwid_check #(
   parameter int MAX_WIDTH = cwid_pkg::MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cwid_pkg::req_type    req_data,
   output cwid_pkg::ctl_type    dn_ctl,
   output logic [MAX_WIDTH-1:0] dn_dvd,
   output logic [MAX_WIDTH-1:0] dn_dvs
);
   import cwid_pkg::*;

   logic [DATA_W-1:0]    mask;
   logic [DATA_W-1:0]    sign_bit;
   logic [DATA_W-1:0]    x_neg;
   logic [DATA_W-1:0]    y_neg;
   logic                 width_bad;
   logic                 range_bad;
   logic                 nx;
   logic                 ny;
   status_type           status;
   ctl_type              ctl_in;
   ctl_type              ctl_ff;
   logic [MAX_WIDTH-1:0] dvd_in;
   logic [MAX_WIDTH-1:0] dvd_ff;
   logic [MAX_WIDTH-1:0] dvs_in;
   logic [MAX_WIDTH-1:0] dvs_ff;

   always_comb begin
      // a shift of 64 or more clears, so the minus one gives all ones
      mask      = (DATA_W'(1) << req_data.operand_width) - DATA_W'(1);
      sign_bit  = DATA_W'(1) << (req_data.operand_width - OPW_W'(1));
      width_bad = (req_data.operand_width == '0) ||
                  (req_data.operand_width > OPW_W'(MAX_WIDTH));
      range_bad = ((req_data.dividend & ~mask) != '0) ||
                  ((req_data.divisor & ~mask) != '0);
      nx        = req_data.signed_mode && ((req_data.dividend & sign_bit) != '0);
      ny        = req_data.signed_mode && ((req_data.divisor & sign_bit) != '0);
      x_neg     = (DATA_W'(0) - req_data.dividend) & mask;
      y_neg     = (DATA_W'(0) - req_data.divisor) & mask;

      if (width_bad || range_bad) begin
         status = STATUS_TYPE;
      end else if (req_data.divisor == '0) begin
         status = STATUS_DIV0;
      end else if (req_data.signed_mode && (req_data.dividend == sign_bit) &&
                   (req_data.divisor == mask)) begin
         status = STATUS_OVF;
      end else begin
         status = STATUS_OK;
      end

      ctl_in.valid  = start;
      ctl_in.status = status;
      ctl_in.neg_q  = nx ^ ny;
      ctl_in.width  = req_data.operand_width;
      dvd_in = nx ? x_neg[MAX_WIDTH-1:0] : req_data.dividend[MAX_WIDTH-1:0];
      dvs_in = ny ? y_neg[MAX_WIDTH-1:0] : req_data.divisor[MAX_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign dn_ctl = ctl_ff;
   assign dn_dvd = dvd_ff;
   assign dn_dvs = dvs_ff;

endmodule

### rtl/core/cwid_div_stage.sv
// ----------------------------------------------------------------------------
// cwid_div_stage
// One restoring radix-2 step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module cwid_div_stage #(
   parameter int MAX_WIDTH = cwid_pkg::MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cwid_pkg::ctl_type    up_ctl,
   input  logic [MAX_WIDTH-1:0] up_rem,
   input  logic [MAX_WIDTH-1:0] up_dvd,
   input  logic [MAX_WIDTH-1:0] up_dvs,
   output cwid_pkg::ctl_type    dn_ctl,
   output logic [MAX_WIDTH-1:0] dn_rem,
   output logic [MAX_WIDTH-1:0] dn_dvd,
   output logic [MAX_WIDTH-1:0] dn_dvs
);
   import cwid_pkg::*;

   logic [MAX_WIDTH:0]   trial;
   logic [MAX_WIDTH:0]   diff;
   logic                 fits;
   ctl_type              ctl_ff;
   logic [MAX_WIDTH-1:0] rem_in;
   logic [MAX_WIDTH-1:0] rem_ff;
   logic [MAX_WIDTH-1:0] dvd_in;
   logic [MAX_WIDTH-1:0] dvd_ff;
   logic [MAX_WIDTH-1:0] dvs_ff;

   always_comb begin
      trial  = {up_rem, up_dvd[MAX_WIDTH-1]};
      diff   = trial - {1'b0, up_dvs};
      fits   = !diff[MAX_WIDTH];
      rem_in = fits ? diff[MAX_WIDTH-1:0] : trial[MAX_WIDTH-1:0];
      // dividend bits shift out the top, quotient bits fill in from the bottom
      dvd_in = {up_dvd[MAX_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= up_dvs;
   end

   assign dn_ctl = ctl_ff;
   assign dn_rem = rem_ff;
   assign dn_dvd = dvd_ff;
   assign dn_dvs = dvs_ff;

endmodule

### rtl/core/cwid_fixup.sv
// ----------------------------------------------------------------------------
// cwid_fixup
// Output stage: quotient sign, width mask and zeroing on error.
// ----------------------------------------------------------------------------
module cwid_fixup #(
   parameter int MAX_WIDTH = cwid_pkg::MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cwid_pkg::ctl_type    up_ctl,
   input  logic [MAX_WIDTH-1:0] up_quot,
   output logic                 rsp_valid,
   output cwid_pkg::rsp_type    rsp_data
);
   import cwid_pkg::*;

   logic [DATA_W-1:0] mask;
   logic [DATA_W-1:0] q_ext;
   logic [DATA_W-1:0] q_signed;
   rsp_type           rsp_in;
   rsp_type           rsp_ff;
   logic              valid_ff;

   always_comb begin
      mask     = (DATA_W'(1) << up_ctl.width) - DATA_W'(1);
      q_ext    = DATA_W'(up_quot);
      q_signed = up_ctl.neg_q ? ((DATA_W'(0) - q_ext) & mask) : q_ext;
      rsp_in.status   = up_ctl.status;
      rsp_in.quotient = (up_ctl.status == STATUS_OK) ? q_signed : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/checked_width_integer_divider_top.sv
// ----------------------------------------------------------------------------
// checked_width_integer_divider_top
// Pipelined signed/unsigned integer divider with width and status checks.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle with start high; busy is always low.
// Each transaction yields one result, strobed by rsp_valid for one cycle, in
// order. It passes through one check stage, one restoring stage per quotient
// bit (MAX_WIDTH of them) and one output stage. There is no result
// back-pressure, so the receiver must take every result in the cycle it appears.
module checked_width_integer_divider_top #(
   parameter int MAX_WIDTH = cwid_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cwid_pkg::req_type req_data,
   output logic              rsp_valid,
   output cwid_pkg::rsp_type rsp_data
);
   import cwid_pkg::*;

   ctl_type              ctl_w [MAX_WIDTH+1];
   logic [MAX_WIDTH-1:0] rem_w [MAX_WIDTH+1];
   logic [MAX_WIDTH-1:0] dvd_w [MAX_WIDTH+1];
   logic [MAX_WIDTH-1:0] dvs_w [MAX_WIDTH+1];

   assign busy     = 1'b0;
   assign rem_w[0] = '0;

   cwid_check #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_check (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .dn_ctl   (ctl_w[0]),
      .dn_dvd   (dvd_w[0]),
      .dn_dvs   (dvs_w[0])
   );

   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_stage
      cwid_div_stage #(
         .MAX_WIDTH(MAX_WIDTH)
      ) u_stage (
         .clock  (clock),
         .reset  (reset),
         .up_ctl (ctl_w[i]),
         .up_rem (rem_w[i]),
         .up_dvd (dvd_w[i]),
         .up_dvs (dvs_w[i]),
         .dn_ctl (ctl_w[i+1]),
         .dn_rem (rem_w[i+1]),
         .dn_dvd (dvd_w[i+1]),
         .dn_dvs (dvs_w[i+1])
      );
   end

   cwid_fixup #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_fixup (
      .clock     (clock),
      .reset     (reset),
      .up_ctl    (ctl_w[MAX_WIDTH]),
      .up_quot   (dvd_w[MAX_WIDTH]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
